/* sv/cbac_pkg.sv */
// Package for the contiguous block allocator with compaction.
// Holds sizes, operation and status codes, and the request and result word types.
// No dependencies.
`default_nettype none

package cbac_pkg;

    localparam int BLOCKS = 32;
    localparam int SLOTS  = 16;
    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int CNT_W  = $clog2(BLOCKS + 1);
    localparam int SIDX_W = $clog2(SLOTS);

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_COMPACT = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MOVED   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_BADSLOT = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] slot;
        logic [5:0] length;
    } req_t;

    typedef struct packed {
        logic [3:0] result_slot;
        logic [4:0] start_block;
        logic [1:0] status;
        logic       last;
    } rsp_t;

endpackage

`default_nettype wire

/* sv/cbac_run_mask.sv */
// Run mask unit: sets the block map bits of a run given its start and length.
// Shared for allocation, free and the rebuild after compaction. Uses cbac_pkg.
`default_nettype none

module cbac_run_mask (
    input  wire logic [cbac_pkg::BLK_W-1:0]  start,
    input  wire logic [cbac_pkg::CNT_W-1:0]  length,
    output logic      [cbac_pkg::BLOCKS-1:0] mask
);
    import cbac_pkg::*;

    logic [CNT_W:0] run_end;

    assign run_end = (CNT_W + 1)'(start) + (CNT_W + 1)'(length);

    always_comb
    begin
        for (int i = 0; i < BLOCKS; i++)
        begin
            mask[i] = ((CNT_W + 1)'(i) >= (CNT_W + 1)'(start)) &&
                      ((CNT_W + 1)'(i) < run_end);
        end
    end

endmodule

`default_nettype wire

/* sv/contiguous_block_allocator_compactor_top.sv */
// Top level of the first-fit contiguous block allocator with compaction.
// Sequencer, block map, extent table and result register. Uses cbac_pkg and cbac_run_mask.
// One request is taken at a time. An allocate scans the block map one bit per cycle; if
// no run fits, it compacts the extent table and scans the map once more. Compaction runs
// one pass over the extent table per extent, plus a final pass that finds none left, and
// then rebuilds the block map. A moved-extent word waits while the result register is
// full; the final word of a request leaves the block free to take the next request.
`default_nettype none

module contiguous_block_allocator_compactor_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire cbac_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output cbac_pkg::rsp_t      rsp
);
    import cbac_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIT,
        S_SET,
        S_NOSPACE,
        S_CSCAN,
        S_CPICK,
        S_CDONE
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [3:0]          slot_reg, slot_next;
    logic [5:0]          len_reg, len_next;
    logic [BLOCKS-1:0]   map_reg, map_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic [SLOTS-1:0]    placed_reg, placed_next;
    logic [BLK_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [BLK_W-1:0]    fit_start_reg, fit_start_next;
    logic                retry_reg, retry_next;
    logic                from_alloc_reg, from_alloc_next;
    logic [SIDX_W-1:0]   scan_reg, scan_next;
    logic [SIDX_W-1:0]   best_reg, best_next;
    logic [BLK_W-1:0]    best_start_reg, best_start_next;
    logic                have_reg, have_next;
    logic [CNT_W-1:0]    cursor_reg, cursor_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic [BLK_W-1:0]    ext_start [SLOTS];
    logic [CNT_W-1:0]    ext_len [SLOTS];

    logic [SIDX_W-1:0]   slot_idx;
    logic                slot_ok;
    logic [SIDX_W-1:0]   rd_idx;
    logic [BLK_W-1:0]    rd_start;
    logic [CNT_W-1:0]    rd_len;
    logic                st_we;
    logic                len_we;
    logic [SIDX_W-1:0]   wr_idx;
    logic [BLK_W-1:0]    wr_start;
    logic [CNT_W-1:0]    wr_len;
    logic [BLK_W-1:0]    mask_start;
    logic [CNT_W-1:0]    mask_len;
    logic [BLOCKS-1:0]   mask;
    logic                emit_req;
    logic                emit_ok;
    logic                emit_fire;
    rsp_t                emit_word;
    logic [CNT_W-1:0]    run_n;
    logic                found;
    logic                cand;
    logic                moved;

    cbac_run_mask u_run_mask (
        .start  (mask_start),
        .length (mask_len),
        .mask   (mask)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign slot_idx  = slot_reg[SIDX_W-1:0];
    assign slot_ok   = (int'(slot_reg) < SLOTS);
    assign wr_len    = CNT_W'(len_reg);
    assign emit_ok   = !rsp_valid_reg || rsp_ready;
    assign emit_fire = emit_req && emit_ok;

    assign run_n = map_reg[pos_reg] ? '0 : run_reg + 1'b1;
    assign found = ((CNT_W + 7)'(run_n) == (CNT_W + 7)'(len_reg));
    assign cand  = used_reg[scan_reg] && !placed_reg[scan_reg] &&
                   (!have_reg || (rd_start < best_start_reg));
    assign moved = ((CNT_W + 1)'(best_start_reg) != (CNT_W + 1)'(cursor_reg));

    always_comb
    begin
        case (state_reg)
            S_CSCAN: rd_idx = scan_reg;
            S_CPICK: rd_idx = best_reg;
            default: rd_idx = slot_idx;
        endcase
    end

    assign rd_start = ext_start[rd_idx];
    assign rd_len   = ext_len[rd_idx];

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        len_next        = len_reg;
        map_next        = map_reg;
        used_next       = used_reg;
        placed_next     = placed_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        fit_start_next  = fit_start_reg;
        retry_next      = retry_reg;
        from_alloc_next = from_alloc_reg;
        scan_next       = scan_reg;
        best_next       = best_reg;
        best_start_next = best_start_reg;
        have_next       = have_reg;
        cursor_next     = cursor_reg;
        emit_req        = 1'b0;
        emit_word       = '{result_slot: slot_reg, start_block: '0,
                            status: ST_BADSLOT, last: 1'b1};
        st_we           = 1'b0;
        len_we          = 1'b0;
        wr_idx          = slot_idx;
        wr_start        = fit_start_reg;
        mask_start      = fit_start_reg;
        mask_len        = CNT_W'(len_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    slot_next  = req.slot;
                    len_next   = req.length;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (!slot_ok || used_reg[slot_idx])
                        begin
                            emit_req = 1'b1;
                        end
                        else if (len_reg == '0)
                        begin
                            emit_req         = 1'b1;
                            emit_word.status = ST_DONE;
                        end
                        else
                        begin
                            pos_next   = '0;
                            run_next   = '0;
                            retry_next = 1'b0;
                            state_next = S_FIT;
                        end
                        if (emit_fire)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    OP_FREE:
                    begin
                        emit_req = 1'b1;
                        if (slot_ok && used_reg[slot_idx])
                        begin
                            emit_word.status      = ST_DONE;
                            emit_word.start_block = 5'(rd_start);
                            mask_start            = rd_start;
                            mask_len              = rd_len;
                            if (emit_fire)
                            begin
                                map_next            = map_reg & ~mask;
                                used_next[slot_idx] = 1'b0;
                            end
                        end
                        if (emit_fire)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    OP_COMPACT:
                    begin
                        placed_next     = '0;
                        cursor_next     = '0;
                        scan_next       = '0;
                        have_next       = 1'b0;
                        from_alloc_next = 1'b0;
                        state_next      = S_CSCAN;
                    end
                    default:
                    begin
                        emit_req = 1'b1;
                        if (emit_fire)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_FIT:
            begin
                run_next = run_n;
                if (found)
                begin
                    fit_start_next = BLK_W'((CNT_W + 7)'(pos_reg) + (CNT_W + 7)'(1) -
                                            (CNT_W + 7)'(len_reg));
                    state_next     = S_SET;
                end
                else if (pos_reg == BLK_W'(BLOCKS - 1))
                begin
                    if (retry_reg)
                    begin
                        state_next = S_NOSPACE;
                    end
                    else
                    begin
                        placed_next     = '0;
                        cursor_next     = '0;
                        scan_next       = '0;
                        have_next       = 1'b0;
                        from_alloc_next = 1'b1;
                        state_next      = S_CSCAN;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_SET:
            begin
                emit_req              = 1'b1;
                emit_word.status      = ST_DONE;
                emit_word.start_block = 5'(fit_start_reg);
                if (emit_fire)
                begin
                    map_next            = map_reg | mask;
                    used_next[slot_idx] = 1'b1;
                    st_we               = 1'b1;
                    len_we              = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            S_NOSPACE:
            begin
                emit_req         = 1'b1;
                emit_word.status = ST_NOSPACE;
                if (emit_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CSCAN:
            begin
                if (cand)
                begin
                    best_next       = scan_reg;
                    best_start_next = rd_start;
                    have_next       = 1'b1;
                end
                if (scan_reg == SIDX_W'(SLOTS - 1))
                begin
                    state_next = S_CPICK;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_CPICK:
            begin
                if (!have_reg)
                begin
                    mask_start = '0;
                    mask_len   = cursor_reg;
                    map_next   = mask;
                    if (from_alloc_reg)
                    begin
                        retry_next = 1'b1;
                        pos_next   = '0;
                        run_next   = '0;
                        state_next = S_FIT;
                    end
                    else
                    begin
                        state_next = S_CDONE;
                    end
                end
                else
                begin
                    emit_req              = moved;
                    emit_word.result_slot = 4'(best_reg);
                    emit_word.start_block = 5'(cursor_reg);
                    emit_word.status      = ST_MOVED;
                    emit_word.last        = 1'b0;
                    if (!moved || emit_fire)
                    begin
                        placed_next[best_reg] = 1'b1;
                        st_we                 = moved;
                        wr_idx                = best_reg;
                        wr_start              = BLK_W'(cursor_reg);
                        cursor_next           = cursor_reg + rd_len;
                        scan_next             = '0;
                        have_next             = 1'b0;
                        state_next            = S_CSCAN;
                    end
                end
            end
            S_CDONE:
            begin
                emit_req              = 1'b1;
                emit_word.result_slot = '0;
                emit_word.status      = ST_DONE;
                if (emit_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_fire)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_word;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && !rsp_ready;
            rsp_next       = rsp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            slot_reg       <= '0;
            len_reg        <= '0;
            map_reg        <= '0;
            used_reg       <= '0;
            placed_reg     <= '0;
            pos_reg        <= '0;
            run_reg        <= '0;
            fit_start_reg  <= '0;
            retry_reg      <= 1'b0;
            from_alloc_reg <= 1'b0;
            scan_reg       <= '0;
            best_reg       <= '0;
            best_start_reg <= '0;
            have_reg       <= 1'b0;
            cursor_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            slot_reg       <= slot_next;
            len_reg        <= len_next;
            map_reg        <= map_next;
            used_reg       <= used_next;
            placed_reg     <= placed_next;
            pos_reg        <= pos_next;
            run_reg        <= run_next;
            fit_start_reg  <= fit_start_next;
            retry_reg      <= retry_next;
            from_alloc_reg <= from_alloc_next;
            scan_reg       <= scan_next;
            best_reg       <= best_next;
            best_start_reg <= best_start_next;
            have_reg       <= have_next;
            cursor_reg     <= cursor_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            ext_start[wr_idx] <= wr_start;
        end
        if (len_we)
        begin
            ext_len[wr_idx] <= wr_len;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_DECODE)
        else $error("Accepted request did not reach decode.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIT |-> (CNT_W + 7)'(run_reg) < (CNT_W + 7)'(len_reg))
        else $error("Free run count passed the requested length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CPICK && !have_reg |-> int'(cursor_reg) <= BLOCKS)
        else $error("Compacted extents exceed the block count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.status == ST_MOVED && rsp_reg.last))
        else $error("Moved-extent word marked as the final word.");
`endif

endmodule

`default_nettype wire
